// File: rtl/core/rws_pkg.sv
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Field widths, opcodes and parameter defaults shared by the selector core.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int CFG_W    = 11;
    localparam int CFG_RST  = 1024;
    localparam int IDX_W    = 10;
    localparam int WVAL_W   = 16;
    localparam int RAND_W   = 16;
    localparam int SIDX_W   = 10;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

endpackage

// File: rtl/core/rws_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/roulette_wheel_selector_top.sv
// ----------------------------------------------------------------------------
// Roulette wheel selector
// Fitness-proportionate selection over a table of unsigned weights.
// ----------------------------------------------------------------------------
// After reset the block clears its weight table, one entry per cycle, and
// takes no item meanwhile (configuration writes are taken at any time). A
// draw with n entries in use makes one pass of n reads through the weight RAM
// read port to form the total, 16 shift-add steps of the shared adder to scale
// the total by the random fraction, and a second pass of at most n reads that
// stops at the chosen entry. If the total is zero, n is scaled instead and the
// scaled value is the pick, with no second pass. The block takes no item until
// the draw's result is in the output register.
module roulette_wheel_selector_top #(
    parameter int MAX_ENTRIES = rws_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = rws_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rws_pkg::CFG_W-1:0]   i_cfg_data,    // entries_in_use
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // entry_index[9:0], weight_value[25:10], random_fraction[41:26], zeros
    input  logic [rws_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tuser,  // opcode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rws_pkg::M_DATA_W-1:0] m_axis_tdata, // selected_index[9:0], zeros
    output logic                        m_axis_tuser   // total_was_zero
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int NW  = $clog2(MAX_ENTRIES + 1);
    localparam int TW  = WEIGHT_BITS + NW;
    localparam int PW  = TW + rws_pkg::RAND_W;
    localparam int BCW = $clog2(rws_pkg::RAND_W);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [rws_pkg::CFG_W-1:0]     r_cfg;
    logic [NW-1:0]                 r_n, n_n;
    logic [rws_pkg::RAND_W-1:0]    r_r, n_r;
    logic [AW-1:0]                 r_ra, n_ra;
    logic                          r_go, n_go;
    logic                          r_rv, n_rv;
    logic                          r_rl, n_rl;
    logic [AW-1:0]                 r_di, n_di;
    logic [PW-1:0]                 r_acc, n_acc;
    logic [TW-1:0]                 r_opnd, n_opnd;
    logic [TW-1:0]                 r_thr, n_thr;
    logic                          r_zero, n_zero;
    logic [BCW-1:0]                r_bc, n_bc;
    logic [AW-1:0]                 r_pick, n_pick;
    logic                          r_ovld, n_ovld;
    logic [rws_pkg::SIDX_W-1:0]    r_osel, n_osel;
    logic                          r_ozero, n_ozero;

    logic [rws_pkg::IDX_W-1:0]     w_idx;
    logic [rws_pkg::WVAL_W-1:0]    w_wval;
    logic [rws_pkg::RAND_W-1:0]    w_rand;
    logic                          w_s_acc;
    logic [31:0]                   w_n32;
    logic [AW-1:0]                 w_last;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [WEIGHT_BITS-1:0]        w_wdata;
    logic [WEIGHT_BITS-1:0]        w_rdata;
    logic [PW-1:0]                 w_add_a;
    logic [PW-1:0]                 w_add_b;
    logic [PW-1:0]                 w_sum;
    logic                          w_out_free;

    assign w_idx   = s_axis_tdata[9:0];
    assign w_wval  = s_axis_tdata[25:10];
    assign w_rand  = s_axis_tdata[41:26];
    assign w_s_acc = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {{(rws_pkg::M_DATA_W - rws_pkg::SIDX_W){1'b0}}, r_osel};
    assign m_axis_tuser  = r_ozero;

    always_comb begin
        w_n32 = 32'(r_cfg);
        if (w_n32 == 32'd0) begin
            w_n32 = 32'd1;
        end else if (w_n32 > 32'(MAX_ENTRIES)) begin
            w_n32 = 32'(MAX_ENTRIES);
        end
    end

    assign w_last = AW'(r_n - NW'(1));

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_ra;
            w_wdata = '0;
        end else begin
            w_we    = w_s_acc && (s_axis_tuser == rws_pkg::OP_WRITE)
                      && (32'(w_idx) < 32'(MAX_ENTRIES));
            w_waddr = AW'(w_idx);
            w_wdata = WEIGHT_BITS'(w_wval);
        end
    end

    rws_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ra),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_state == ST_MUL) begin
            w_add_a = {r_acc[PW-2:0], 1'b0};
            w_add_b = r_r[r_bc] ? PW'(r_opnd) : '0;
        end else begin
            w_add_a = r_acc;
            w_add_b = PW'(w_rdata);
        end
    end

    assign w_sum      = w_add_a + w_add_b;
    assign w_out_free = !r_ovld || m_axis_tready;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_r     = r_r;
        n_ra    = r_ra;
        n_go    = r_go;
        n_rv    = 1'b0;
        n_rl    = r_rl;
        n_di    = r_di;
        n_acc   = r_acc;
        n_opnd  = r_opnd;
        n_thr   = r_thr;
        n_zero  = r_zero;
        n_bc    = r_bc;
        n_pick  = r_pick;
        n_ovld  = r_ovld;
        n_osel  = r_osel;
        n_ozero = r_ozero;

        if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end

        if ((r_state == ST_SUM || r_state == ST_SCAN) && r_go) begin
            n_rv = 1'b1;
            n_rl = (r_ra == w_last);
            if (r_ra == w_last) begin
                n_go = 1'b0;
            end else begin
                n_ra = r_ra + AW'(1);
            end
        end

        case (r_state)
            ST_CLEAR: begin
                if (32'(r_ra) == 32'(MAX_ENTRIES - 1)) begin
                    n_ra    = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ra = r_ra + AW'(1);
                end
            end
            ST_IDLE: begin
                if (w_s_acc && (s_axis_tuser == rws_pkg::OP_DRAW)) begin
                    n_n     = NW'(w_n32);
                    n_r     = w_rand;
                    n_ra    = '0;
                    n_go    = 1'b1;
                    n_acc   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_rv) begin
                    n_acc = w_sum;
                    if (r_rl) begin
                        n_zero  = (w_sum == '0);
                        n_opnd  = (w_sum == '0) ? TW'(r_n) : TW'(w_sum);
                        n_acc   = '0;
                        n_bc    = BCW'(rws_pkg::RAND_W - 1);
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_acc = w_sum;
                n_bc  = r_bc - BCW'(1);
                if (r_bc == '0) begin
                    if (r_zero) begin
                        n_pick  = AW'(w_sum[PW-1:rws_pkg::RAND_W]);
                        n_state = ST_OUT;
                    end else begin
                        n_thr   = w_sum[PW-1:rws_pkg::RAND_W];
                        n_acc   = '0;
                        n_ra    = '0;
                        n_go    = 1'b1;
                        n_di    = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rv) begin
                    n_acc = w_sum;
                    n_di  = r_di + AW'(1);
                    if ((w_sum > PW'(r_thr)) || r_rl) begin
                        n_pick  = r_di;
                        n_go    = 1'b0;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_ovld  = 1'b1;
                    n_osel  = rws_pkg::SIDX_W'(r_pick);
                    n_ozero = r_zero;
                    n_ra    = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cfg   <= rws_pkg::CFG_W'(rws_pkg::CFG_RST);
            r_ra    <= '0;
            r_go    <= 1'b0;
            r_rv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            r_ra    <= n_ra;
            r_go    <= n_go;
            r_rv    <= n_rv;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_r     <= n_r;
        r_rl    <= n_rl;
        r_di    <= n_di;
        r_acc   <= n_acc;
        r_opnd  <= n_opnd;
        r_thr   <= n_thr;
        r_zero  <= n_zero;
        r_bc    <= n_bc;
        r_pick  <= n_pick;
        r_osel  <= n_osel;
        r_ozero <= n_ozero;
    end

endmodule
